/* rtl/core/tcpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// Command, status and state codes for the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_ANY    = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_NOTFD = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam int NCLASS = 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_LNK  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;

    typedef logic [2:0] t_state;

endpackage

/* rtl/core/three_class_priority_queue_with_cancel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_class_priority_queue_with_cancel
// Strict-priority queue, three FIFO classes, lookup and removal by code.
// Add, lookup and remove scan all CAPACITY slots, one per cycle, then compare,
// read and execute; a mid-list remove adds a relink step. Peek only reads and
// executes; any-waiting and unused commands go straight to output. One word at a
// time; the next word is taken the cycle after the result word leaves.
// Reset clears valid bits and class pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module three_class_priority_queue_with_cancel #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_entry_code,
    input  logic [7:0]  i_entry_age,
    input  logic [1:0]  i_priority_class,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_code,
    output logic [7:0]  o_found_age,
    output logic [1:0]  o_found_class,
    output logic        o_any_waiting
);
    import tcpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   m_code [CAPACITY];
    logic [7:0]    m_age  [CAPACITY];
    logic [1:0]    m_cls  [CAPACITY];
    logic [AW-1:0] m_prev [CAPACITY];
    logic [AW-1:0] m_next [CAPACITY];
    logic [CAPACITY-1:0] r_valid;

    logic [AW-1:0] r_head [NCLASS];
    logic [AW-1:0] r_tail [NCLASS];
    logic [CW-1:0] r_cnt  [NCLASS];

    t_state        r_state;
    logic [2:0]    r_cmd;
    logic [31:0]   r_code;
    logic [7:0]    r_age;
    logic [1:0]    r_cls;
    logic [AW:0]   r_idx;
    logic          r_hit, r_freeok;
    logic [AW-1:0] r_hit_s, r_free_s;
    logic          r_sv;
    logic [AW-1:0] r_sx;

    // registered reads of the slot memories
    logic [31:0]   r_rd_code;
    logic [7:0]    r_rd_age;
    logic [1:0]    r_rd_cls;
    logic [AW-1:0] r_rd_prev, r_rd_next;
    logic [AW-1:0] r_p, r_n;
    logic          r_mid;

    logic [2:0]    r_st;
    logic [31:0]   r_fcode;
    logic [7:0]    r_fage;
    logic [1:0]    r_fcls;
    logic          r_ovalid;

    logic [AW-1:0] w_ix;
    logic [AW-1:0] w_ra;
    logic [1:0]    w_c;
    logic          w_any;

    assign w_ix  = r_idx[AW-1:0];
    assign w_c   = (r_cls == 2'd3) ? 2'd2 : r_cls;
    assign w_any = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);
    assign o_stall = (r_state != S_IDLE) || r_ovalid;

    // read address: scan index, else peek tail or matched slot
    always_comb begin
        if (r_state == S_SCAN) begin
            w_ra = w_ix;
        end else if (r_cmd == CMD_PEEK) begin
            if (r_cnt[2] != '0)      w_ra = r_tail[2];
            else if (r_cnt[1] != '0) w_ra = r_tail[1];
            else                     w_ra = r_tail[0];
        end else begin
            w_ra = r_hit_s;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        r_rd_code <= m_code[w_ra];
        r_rd_age  <= m_age[w_ra];
        r_rd_cls  <= m_cls[w_ra];
        r_rd_prev <= m_prev[w_ra];
        r_rd_next <= m_next[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_sv     <= 1'b0;
            for (int k = 0; k < NCLASS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            // code compare in the cycle after the scan read
            r_sv <= (r_state == S_SCAN);
            r_sx <= w_ix;
            if (r_sv && !r_hit && r_valid[r_sx] && r_rd_code == r_code) begin
                r_hit   <= 1'b1;
                r_hit_s <= r_sx;
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_cmd   <= i_command;
                        r_code  <= i_entry_code;
                        r_age   <= i_entry_age;
                        r_cls   <= i_priority_class;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_freeok <= 1'b0;
                        r_st    <= ST_OK;
                        r_fcode <= '0;
                        r_fage  <= '0;
                        r_fcls  <= '0;
                        if (i_command == CMD_ADD || i_command == CMD_LOOKUP ||
                            i_command == CMD_REMOVE) begin
                            r_state <= S_SCAN;
                        end else if (i_command == CMD_PEEK) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_valid[w_ix] && !r_freeok) begin
                        r_freeok <= 1'b1;
                        r_free_s <= w_ix;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (AW+1)'(CAPACITY - 1)) r_state <= S_CMP;
                end
                S_CMP: r_state <= S_RD;
                S_RD: r_state <= S_EXEC;
                S_EXEC: begin
                    r_state <= S_OUT;
                    unique case (r_cmd)
                        CMD_PEEK: begin
                            if (!w_any) begin
                                r_st <= ST_EMPTY;
                            end else begin
                                r_fcode <= r_rd_code;
                                r_fcls  <= (r_cnt[2] != '0) ? 2'd2 :
                                           (r_cnt[1] != '0) ? 2'd1 : 2'd0;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (!r_hit) begin
                                r_st <= ST_NOTFD;
                            end else begin
                                r_fage <= r_rd_age;
                                r_fcls <= r_rd_cls;
                            end
                        end
                        CMD_ADD: begin
                            if (r_hit) begin
                                r_st <= ST_DUP;
                            end else if (!r_freeok) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_valid[r_free_s] <= 1'b1;
                                if (r_cnt[w_c] == '0) r_tail[w_c] <= r_free_s;
                                r_head[w_c] <= r_free_s;
                                r_cnt[w_c]  <= r_cnt[w_c] + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_hit) begin
                                r_valid[r_hit_s] <= 1'b0;
                                r_mid <= 1'b0;
                                r_p   <= r_rd_prev;
                                r_n   <= r_rd_next;
                                if (r_cnt[r_rd_cls] > CW'(1)) begin
                                    if (r_hit_s == r_head[r_rd_cls])
                                        r_head[r_rd_cls] <= r_rd_next;
                                    else if (r_hit_s == r_tail[r_rd_cls])
                                        r_tail[r_rd_cls] <= r_rd_prev;
                                    else begin
                                        r_mid   <= 1'b1;
                                        r_state <= S_LNK;
                                    end
                                end
                                if (r_cnt[r_rd_cls] != '0)
                                    r_cnt[r_rd_cls] <= r_cnt[r_rd_cls] - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LNK: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // slot memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_cmd == CMD_ADD && !r_hit && r_freeok) begin
            m_code[r_free_s] <= r_code;
            m_age[r_free_s]  <= r_age;
            m_cls[r_free_s]  <= w_c;
            m_prev[r_free_s] <= r_free_s;
            m_next[r_free_s] <= (r_cnt[w_c] == '0) ? r_free_s : r_head[w_c];
        end else if (r_state == S_LNK && r_mid) begin
            m_next[r_p] <= r_n;
        end
        if (r_state == S_EXEC && r_cmd == CMD_ADD && !r_hit && r_freeok &&
            r_cnt[w_c] != '0) begin
            m_prev[r_head[w_c]] <= r_free_s;
        end else if (r_state == S_LNK && r_mid) begin
            m_prev[r_n] <= r_p;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_st;
    assign o_found_code  = r_fcode;
    assign o_found_age   = r_fage;
    assign o_found_class = r_fcls;
    assign o_any_waiting = w_any;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CW'(CAPACITY)) && (r_cnt[2] <= CW'(CAPACITY)))
        else $error("class count overflow");
endmodule

/* tb/sv/tb_three_class_priority_queue_with_cancel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_class_priority_queue_with_cancel
// Self-checking bench for the three-class priority queue. A scoreboard keeps
// its own copy of the store and the per-class FIFO order and predicts each
// result word. Directed words cover the corners, then random traffic with
// a working set of codes, idling on both sides and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_three_class_priority_queue_with_cancel;
    import tcpq_pkg::*;

    localparam int CAP      = 64;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] code;
        logic [7:0]  age;
        logic [1:0]  cls;
    } t_cmd_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] code;
        logic [7:0]  age;
        logic [1:0]  cls;
        logic        any;
    } t_resp_word;

    typedef struct {
        logic [31:0] code;
        logic [7:0]  age;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [31:0] i_entry_code = '0;
    logic [7:0]  i_entry_age = '0;
    logic [1:0]  i_priority_class = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_found_code;
    logic [7:0]  o_found_age;
    logic [1:0]  o_found_class;
    logic        o_any_waiting;

    three_class_priority_queue_with_cancel #(.CAPACITY(CAP)) dut (.*);

    always #10 i_clk = ~i_clk;

    t_cmd_word  pending_cmds[$];
    t_resp_word expected_resps[$];
    t_entry     class_fifo[3][$];   // index 0 oldest
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_recv = 0;
    bit         send_pause = 0;
    int         quiet_cycles = 0;
    logic [31:0] code_pool[16];

    function automatic int stored_total();
        return class_fifo[0].size() + class_fifo[1].size() + class_fifo[2].size();
    endfunction

    function automatic t_resp_word queue_predict(t_cmd_word w);
        t_resp_word r;
        int c;
        int idx;
        int hit_c;
        int hit_i;
        logic [1:0] cl;
        r = '0;
        cl = (w.cls == 2'd3) ? 2'd2 : w.cls;
        hit_c = -1;
        hit_i = -1;
        for (c = 0; c < 3; c++)
            for (idx = 0; idx < class_fifo[c].size(); idx++)
                if (class_fifo[c][idx].code == w.code) begin
                    hit_c = c;
                    hit_i = idx;
                end
        case (w.cmd)
            CMD_ADD: begin
                if (hit_c >= 0) r.status = ST_DUP;
                else if (stored_total() >= CAP) r.status = ST_FULL;
                else class_fifo[cl].push_back('{w.code, w.age});
            end
            CMD_LOOKUP: begin
                if (hit_c < 0) r.status = ST_NOTFD;
                else begin
                    r.age = class_fifo[hit_c][hit_i].age;
                    r.cls = hit_c[1:0];
                end
            end
            CMD_PEEK: begin
                r.status = ST_EMPTY;
                for (c = 2; c >= 0; c--)
                    if (r.status == ST_EMPTY && class_fifo[c].size() != 0) begin
                        r.status = ST_OK;
                        r.code = class_fifo[c][0].code;
                        r.cls = c[1:0];
                    end
            end
            CMD_REMOVE: begin
                if (hit_c >= 0) class_fifo[hit_c].delete(hit_i);
            end
            default: ;
        endcase
        r.any = (stored_total() != 0);
        return r;
    endfunction

    function automatic t_cmd_word mk(logic [2:0] c, logic [31:0] k, logic [7:0] a,
                                     logic [1:0] p);
        t_cmd_word w;
        w.cmd = c;
        w.code = k;
        w.age = a;
        w.cls = p;
        return w;
    endfunction

    function automatic t_cmd_word rand_word();
        int sel;
        logic [31:0] k;
        sel = $urandom_range(0, 99);
        k = ($urandom_range(0, 9) == 0) ? $urandom() : code_pool[$urandom_range(0, 15)];
        if (sel < 40) return mk(CMD_ADD, k, 8'($urandom()), 2'($urandom()));
        if (sel < 55) return mk(CMD_LOOKUP, k, 8'($urandom()), 2'($urandom()));
        if (sel < 67) return mk(CMD_PEEK, $urandom(), 8'($urandom()), 2'($urandom()));
        if (sel < 72) return mk(CMD_ANY, $urandom(), 8'($urandom()), 2'($urandom()));
        if (sel < 97) return mk(CMD_REMOVE, k, 8'($urandom()), 2'($urandom()));
        return mk(3'($urandom_range(5, 7)), $urandom(), 8'($urandom()), 2'($urandom()));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_cmds.size() != 0 && !send_pause
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_cmd_word w;
                    w = pending_cmds.pop_front();
                    expected_resps.push_back(queue_predict(w));
                    i_valid <= 1'b1;
                    i_command <= w.cmd;
                    i_entry_code <= w.code;
                    i_entry_age <= w.age;
                    i_priority_class <= w.cls;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_recv > 0) begin
            hold_recv <= hold_recv - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_resp_word e;
            if (expected_resps.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = expected_resps.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_found_code !== e.code) begin
                    $error("found_code exp %h got %h", e.code, o_found_code); errors++;
                end
                if (o_found_age !== e.age) begin
                    $error("found_age exp %0d got %0d", e.age, o_found_age); errors++;
                end
                if (o_found_class !== e.cls) begin
                    $error("found_class exp %0d got %0d", e.cls, o_found_class); errors++;
                end
                if (o_any_waiting !== e.any) begin
                    $error("any_waiting exp %0d got %0d", e.any, o_any_waiting); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    endtask

    initial begin
        int i;
        for (i = 0; i < 16; i++) code_pool[i] = $urandom();
        code_pool[0] = 32'h0;
        code_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_ANY, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h1234, 0, 0));
        pending_cmds.push_back(mk(CMD_ADD, 32'h0, 8'h00, 2'd0));
        pending_cmds.push_back(mk(CMD_ADD, 32'hFFFF_FFFF, 8'hFF, 2'd1));
        pending_cmds.push_back(mk(CMD_ADD, 32'hA5A5_5A5A, 8'h55, 2'd3));
        pending_cmds.push_back(mk(CMD_ADD, 32'h0, 8'hAA, 2'd2));
        pending_cmds.push_back(mk(CMD_LOOKUP, 32'hA5A5_5A5A, 0, 0));
        pending_cmds.push_back(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'hA5A5_5A5A, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(mk(3'd5, 32'hFFFF_FFFF, 8'hFF, 2'd3));
        pending_cmds.push_back(mk(3'd7, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_REMOVE, 32'h0, 0, 0));
        pending_cmds.push_back(mk(CMD_ANY, 0, 0, 0));
        drain();

        // fill to capacity and past, then empty in mixed order
        for (i = 0; i < CAP + 2; i++)
            pending_cmds.push_back(mk(CMD_ADD, 32'h1000 + i, 8'(i),
                                      2'($urandom_range(0, 3))));
        pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        for (i = 0; i < CAP; i++) begin
            pending_cmds.push_back(mk(CMD_REMOVE, 32'h1000 + ((i * 37) % CAP), 0, 0));
            if (i % 8 == 0) pending_cmds.push_back(mk(CMD_PEEK, 0, 0, 0));
        end
        drain();

        // random phases
        send_idle_pct = 9;
        recv_idle_pct = 77;
        for (i = 0; i < 500; i++) pending_cmds.push_back(rand_word());
        drain();
        send_idle_pct = 77;
        recv_idle_pct = 9;
        for (i = 0; i < 500; i++) pending_cmds.push_back(rand_word());
        // long receiver hold-off while words keep coming
        hold_recv = 600;
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < 500; i++) pending_cmds.push_back(rand_word());
        // sender pauses mid-stream until every result is back
        wait (pending_cmds.size() < 250);
        send_pause = 1;
        wait (expected_resps.size() == 0);
        send_pause = 0;
        drain();

        repeat (CAP + 20) @(posedge i_clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

/* three_class_priority_queue_with_cancel.f */
rtl/core/tcpq_pkg.sv
rtl/core/three_class_priority_queue_with_cancel.sv
tb/sv/tb_three_class_priority_queue_with_cancel.sv
